FILE: sv/bepc_pkg.sv
`timescale 1ns / 1ps

package bepc_pkg;

  localparam int unsigned WORD_W       = 32;
  localparam int unsigned LIMIT_W      = 16;
  // Twice a 32-bit event count needs one extra bit.
  localparam int unsigned SKIP_W       = WORD_W + 1;

  localparam logic [SKIP_W-1:0] HEADER_WORDS = SKIP_W'(4);
  localparam logic [SKIP_W-1:0] SOURCE_WORDS = SKIP_W'(3);

  typedef enum logic [5:0] {
    PH_HEADER  = 6'b000001,
    PH_SOURCE  = 6'b000010,
    PH_NBANKS  = 6'b000100,
    PH_BANKID  = 6'b001000,
    PH_EVCOUNT = 6'b010000,
    PH_EVENTS  = 6'b100000
  } bepc_phase_e;

  typedef struct packed {
    logic [WORD_W-1:0] payload_word;
    logic              last_word;
  } bepc_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] event_total;
    logic              truncated;
  } bepc_result_t;

endpackage

FILE: sv/bepc_in_if.sv
`timescale 1ns / 1ps

interface bepc_in_if;
  import bepc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] payload_word;
  logic              last_word;

  modport source (output valid, output payload_word, output last_word, input ready);
  modport sink   (input valid, input payload_word, input last_word, output ready);
endinterface

FILE: sv/bepc_out_if.sv
`timescale 1ns / 1ps

interface bepc_out_if;
  import bepc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] event_total;
  logic              truncated;

  modport source (output valid, output event_total, output truncated, input ready);
  modport sink   (input valid, input event_total, input truncated, output ready);
endinterface

FILE: sv/banked_event_packet_counter.sv
`timescale 1ns / 1ps

// Banked event packet counter. Takes the payload of a banked event packet one
// 32-bit word per transfer on in_i, last_word marking the final word. The
// 4-word pulse header and each source section's 3 leading words are skipped;
// per bank the id is compared against bank_limit and, if below it, the event
// count is added to a 32-bit wrapping total; the two words per event are
// skipped. On the last word one transfer leaves on out_o with the total and a
// truncated flag, set unless the packet ended exactly after the header or
// after a whole source section; the per-packet state then clears. Rate: one
// word per cycle, sustained, as long as out_o is drained; each word goes
// through an input register and one pass of the parse logic into the result
// register. A result waiting on out_o holds back only a following last word;
// ordinary words keep flowing. bank_limit resets to 0 (nothing counted); the
// user writes it through bank_limit_we_i / bank_limit_i only while idle, which
// the block itself does not enforce.
module banked_event_packet_counter
  import bepc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               bank_limit_we_i,
  input  logic [LIMIT_W-1:0] bank_limit_i,
  bepc_in_if.sink            in_i,
  bepc_out_if.source         out_o
);

  // Configuration register
  logic [LIMIT_W-1:0] bank_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_limit_q <= '0;
    end else if (bank_limit_we_i) begin
      bank_limit_q <= bank_limit_i;
    end
  end

  // Input register
  logic       s1_valid_q;
  bepc_item_t s1_item_q;
  logic       s1_fire;
  logic       out_free;
  logic       in_take;

  // Output slot is free if empty or being drained this cycle.
  assign out_free = !out_o.valid || out_o.ready;
  // A word advances unless it is a last word with nowhere to put its result.
  assign s1_fire  = s1_valid_q && (!s1_item_q.last_word || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_take  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.payload_word <= in_i.payload_word;
      s1_item_q.last_word    <= in_i.last_word;
    end
  end

  // Parse step
  bepc_result_t step_res;

  bepc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (s1_fire),
    .item_i       (s1_item_q),
    .bank_limit_i (bank_limit_q),
    .result_o     (step_res)
  );

  // Result register
  logic         out_valid_q;
  logic         out_load;
  bepc_result_t out_q;

  assign out_load = s1_fire && s1_item_q.last_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= step_res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_total = out_q.event_total;
  assign out_o.truncated   = out_q.truncated;

  // Checks
  // A processed last word always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
  else $error("last word processed without a result");

  // Input back-pressure only ever comes from a held input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_valid_q && s1_item_q.last_word && !out_free))
  else $error("input stalled without cause");

  // A held word is not overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_item_q)))
  else $error("held input word lost");

endmodule

FILE: sv/bepc_parser.sv
`timescale 1ns / 1ps

// Packet walker: holds the parse state and advances it by one word per step.
module bepc_parser
  import bepc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  bepc_item_t         item_i,
  input  logic [LIMIT_W-1:0] bank_limit_i,
  output bepc_result_t       result_o
);

  bepc_phase_e       phase_q, phase_d;
  logic [SKIP_W-1:0] skip_q, skip_d;
  logic [WORD_W-1:0] banks_q, banks_d;
  logic              bank_ok_q, bank_ok_d;
  logic [WORD_W-1:0] total_q, total_d;
  logic              close_bank;
  logic [WORD_W-1:0] word;

  assign word = item_i.payload_word;

  always_comb begin
    phase_d    = phase_q;
    skip_d     = skip_q;
    banks_d    = banks_q;
    bank_ok_d  = bank_ok_q;
    total_d    = total_q;
    close_bank = 1'b0;

    unique case (phase_q)
      PH_HEADER: begin
        skip_d = skip_q - SKIP_W'(1);
        if (skip_q == SKIP_W'(1)) begin
          phase_d = PH_SOURCE;
          skip_d  = SOURCE_WORDS;
        end
      end
      PH_SOURCE: begin
        skip_d = skip_q - SKIP_W'(1);
        if (skip_q == SKIP_W'(1)) begin
          phase_d = PH_NBANKS;
        end
      end
      PH_NBANKS: begin
        banks_d = word;
        if (word == '0) begin
          phase_d = PH_SOURCE;
          skip_d  = SOURCE_WORDS;
        end else begin
          phase_d = PH_BANKID;
        end
      end
      PH_BANKID: begin
        bank_ok_d = (word < {{(WORD_W-LIMIT_W){1'b0}}, bank_limit_i});
        phase_d   = PH_EVCOUNT;
      end
      PH_EVCOUNT: begin
        if (bank_ok_q) begin
          total_d = total_q + word;
        end
        skip_d = {word, 1'b0};
        if (word == '0) begin
          close_bank = 1'b1;
        end else begin
          phase_d = PH_EVENTS;
        end
      end
      PH_EVENTS: begin
        skip_d = skip_q - SKIP_W'(1);
        if (skip_q == SKIP_W'(1)) begin
          close_bank = 1'b1;
        end
      end
      default: begin
        phase_d = PH_HEADER;
        skip_d  = HEADER_WORDS;
      end
    endcase

    if (close_bank) begin
      banks_d = banks_q - WORD_W'(1);
      if (banks_q == WORD_W'(1)) begin
        phase_d = PH_SOURCE;
        skip_d  = SOURCE_WORDS;
      end else begin
        phase_d = PH_BANKID;
      end
    end
  end

  // Clean end only right at a section boundary.
  assign result_o.event_total = total_d;
  assign result_o.truncated   = !((phase_d == PH_SOURCE) && (skip_d == SOURCE_WORDS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      skip_q    <= HEADER_WORDS;
      banks_q   <= '0;
      bank_ok_q <= 1'b0;
      total_q   <= '0;
    end else if (step_i) begin
      if (item_i.last_word) begin
        phase_q   <= PH_HEADER;
        skip_q    <= HEADER_WORDS;
        banks_q   <= '0;
        bank_ok_q <= 1'b0;
        total_q   <= '0;
      end else begin
        phase_q   <= phase_d;
        skip_q    <= skip_d;
        banks_q   <= banks_d;
        bank_ok_q <= bank_ok_d;
        total_q   <= total_d;
      end
    end
  end

endmodule

FILE: test/tb_banked_event_packet_counter.sv
`timescale 1ns / 1ps

import bepc_pkg::*;

// Expected totals for the packets seen on the input. Keeps its own copy of
// the parse state and of bank_limit, updated per accepted input transfer.
class packet_tally;
  bepc_phase_e        phase;
  logic [SKIP_W-1:0]  skip_left;
  logic [WORD_W-1:0]  banks_left;
  logic               bank_ok;
  logic [WORD_W-1:0]  total;
  logic [LIMIT_W-1:0] limit;
  bepc_result_t       totals_due[$];
  int unsigned        faults;

  function new();
    limit  = '0;
    faults = 0;
    start_packet();
  endfunction

  function void start_packet();
    phase      = PH_HEADER;
    skip_left  = HEADER_WORDS;
    banks_left = '0;
    bank_ok    = 1'b0;
    total      = '0;
  endfunction

  function void start_section();
    phase     = PH_SOURCE;
    skip_left = SOURCE_WORDS;
  endfunction

  function void close_bank();
    banks_left = banks_left - 1'b1;
    if (banks_left == '0) begin
      start_section();
    end else begin
      phase = PH_BANKID;
    end
  endfunction

  function void set_limit(input logic [LIMIT_W-1:0] value);
    limit = value;
  endfunction

  function int unsigned pending();
    return totals_due.size();
  endfunction

  function void take_word(input logic [WORD_W-1:0] w, input logic last);
    bepc_result_t res;
    case (phase)
      PH_HEADER: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == '0) start_section();
      end
      PH_SOURCE: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == '0) phase = PH_NBANKS;
      end
      PH_NBANKS: begin
        banks_left = w;
        if (w == '0) begin
          start_section();
        end else begin
          phase = PH_BANKID;
        end
      end
      PH_BANKID: begin
        bank_ok = (w < WORD_W'(limit));
        phase   = PH_EVCOUNT;
      end
      PH_EVCOUNT: begin
        if (bank_ok) total = total + w;
        skip_left = {w, 1'b0};
        if (skip_left == '0) begin
          close_bank();
        end else begin
          phase = PH_EVENTS;
        end
      end
      default: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == '0) close_bank();
      end
    endcase
    if (last) begin
      res.event_total = total;
      res.truncated   = !((phase == PH_SOURCE) && (skip_left == SOURCE_WORDS));
      totals_due.insert(totals_due.size(), res);
      start_packet();
    end
  endfunction

  function void check_total(input logic [WORD_W-1:0] got_total, input logic got_trunc);
    bepc_result_t due;
    if (totals_due.size() == 0) begin
      $error("unexpected result: event_total %h truncated %b", got_total, got_trunc);
      faults++;
      return;
    end
    due = totals_due.pop_front();
    if (due.event_total !== got_total) begin
      $error("event_total: expected %h, actual %h", due.event_total, got_total);
      faults++;
    end
    if (due.truncated !== got_trunc) begin
      $error("truncated: expected %b, actual %b", due.truncated, got_trunc);
      faults++;
    end
  endfunction
endclass

// Top level. Packets are built as word queues and pushed through the input
// channel one transfer at a time; every accepted word goes into the tally,
// every result transfer is checked against the oldest total it holds.
// bank_limit changes only between phases, once the last total has drained.
module tb_banked_event_packet_counter;

  localparam int unsigned STALL_LIMIT = 4000; // cycles with no transfer at all
  localparam int unsigned HOLD_CYCLES = 400;  // long output back-pressure
  localparam int unsigned PHASE_WORDS = 230;  // rough words per random phase
  localparam int unsigned MIN_PACKETS = 45;

  logic clk_i;
  logic rst_ni;
  logic bank_limit_we_i;
  logic [LIMIT_W-1:0] bank_limit_i;

  bepc_in_if  in_if ();
  bepc_out_if out_if ();

  banked_event_packet_counter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .bank_limit_we_i (bank_limit_we_i),
    .bank_limit_i    (bank_limit_i),
    .in_i            (in_if),
    .out_o           (out_if)
  );

  packet_tally        tally;
  logic [WORD_W-1:0]  pkt_q[$];
  logic [LIMIT_W-1:0] cur_limit;
  bit                 tx_idle;
  bit                 hold_out;
  int unsigned        packets_sent;
  int unsigned        idle_run;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // One word per input transfer; a random gap first unless this packet
  // is sent back to back. valid stays high across a zero gap.
  task automatic put_word(input logic [WORD_W-1:0] w, input logic last);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.payload_word <= w;
    in_if.last_word    <= last;
    do @(posedge clk_i); while (!in_if.ready);
    tally.take_word(w, last);
  endtask

  task automatic send_packet();
    tx_idle = ($urandom_range(0, 3) != 0);
    foreach (pkt_q[i]) put_word(pkt_q[i], i == pkt_q.size() - 1);
    packets_sent++;
  endtask

  // Change bank_limit only once the block has nothing in flight.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    in_if.valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    bank_limit_we_i <= 1'b1;
    bank_limit_i    <= value;
    @(posedge clk_i);
    bank_limit_we_i <= 1'b0;
    tally.set_limit(value);
    cur_limit = value;
  endtask

  // Bank ids clustered around the limit, plus full-width ones.
  function automatic logic [WORD_W-1:0] pick_bank_id();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return (cur_limit == '0) ? '0 : WORD_W'(cur_limit) - 1'b1;
      2: return WORD_W'(cur_limit);
      3: return WORD_W'($urandom_range(0, cur_limit));
      4: return $urandom;
      default: return '1;
    endcase
  endfunction

  task automatic add_word(input logic [WORD_W-1:0] w);
    pkt_q.insert(pkt_q.size(), w);
  endtask

  task automatic push_random(input int unsigned n);
    repeat (n) add_word($urandom);
  endtask

  task automatic build_complete();
    int unsigned n_sec, n_bank, n_ev;
    pkt_q.delete();
    push_random(4);
    n_sec = $urandom_range(0, 3);
    repeat (n_sec) begin
      push_random(3);
      n_bank = $urandom_range(0, 3);
      add_word(n_bank);
      repeat (n_bank) begin
        add_word(pick_bank_id());
        n_ev = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        add_word(n_ev);
        push_random(2 * n_ev);
      end
    end
  endtask

  task automatic build_random_packet();
    int unsigned kind, cut;
    logic [WORD_W-1:0] big;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      build_complete();
      // short packet: stop at any word of an otherwise well-formed one
      if (kind >= 6) begin
        cut   = $urandom_range(1, pkt_q.size());
        pkt_q = pkt_q[0:cut-1];
      end
    end else if (kind == 8) begin
      // huge event count; the packet has to end inside its event words
      pkt_q.delete();
      push_random(7);
      add_word(WORD_W'(1));
      add_word(pick_bank_id());
      big = $urandom_range(0, 1) ? '1 : ($urandom | 32'h8000_0000);
      add_word(big);
      push_random($urandom_range(0, 6));
    end else begin
      pkt_q.delete();
      push_random($urandom_range(1, 12));
    end
  endtask

  task automatic run_phase(input logic [LIMIT_W-1:0] value, input bit hold,
                           input bit closing);
    int unsigned sent;
    write_limit(value);
    if (hold) hold_out = 1'b1;
    sent = 0;
    while (sent < PHASE_WORDS || (closing && packets_sent < MIN_PACKETS)) begin
      build_random_packet();
      sent += pkt_q.size();
      send_packet();
    end
  endtask

  // Result side: random ready gaps, one long hold-off when asked for.
  initial begin
    int unsigned gap;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 16) : 0;
      if (hold_out) begin
        hold_out = 1'b0;
        gap += HOLD_CYCLES;
      end
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      tally.check_total(out_if.event_total, out_if.truncated);
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  initial begin
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    tally        = new();
    cur_limit    = '0;
    hold_out     = 1'b0;
    packets_sent = 0;
    rst_ni             <= 1'b0;
    bank_limit_we_i    <= 1'b0;
    bank_limit_i       <= '0;
    in_if.valid        <= 1'b0;
    in_if.payload_word <= '0;
    in_if.last_word    <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limit of 0: header-only packet, ends cleanly, nothing counted.
    pkt_q = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
    send_packet();

    // Limit 5: bank 4 counted, bank 5 (at the limit, not counted) as a zero-event bank,
    // then a section with no banks closing the packet.
    write_limit(5);
    pkt_q = '{32'h0, 32'h0, 32'h0, 32'h0,
              32'hFFFF_FFFF, 32'h0, 32'h1, 32'h2,
              32'h4, 32'h1, 32'hDEAD_BEEF, 32'h0,
              32'h5, 32'h0,
              32'h1, 32'h2, 32'h3, 32'h0};
    send_packet();
    // Packet of a single word ends inside the header.
    pkt_q = '{32'h0000_1234};
    send_packet();

    run_phase(16'hFFFF, 1'b0, 1'b0);
    run_phase(16'h0001, 1'b0, 1'b0);
    run_phase(16'h0000, 1'b1, 1'b0);
    run_phase(LIMIT_W'($urandom), 1'b0, 1'b0);
    run_phase(LIMIT_W'($urandom_range(2, 16)), 1'b0, 1'b0);
    run_phase(16'hFFFF, 1'b0, 1'b1);

    in_if.valid <= 1'b0;
    while (tally.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tally.pending() != 0) begin
      $error("%0d totals never arrived", tally.pending());
      tally.faults++;
    end
    if (tally.faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
